/* rtl/core/clwr_pkg.sv */
`timescale 1ns / 1ps

package clwr_pkg;

	localparam int MAX_COLUMNS = 40;

	// controller commands and the second line base address
	localparam logic [7:0] CMD_HOME    = 8'h02;
	localparam logic [7:0] CMD_SETADDR = 8'h80;
	localparam logic [6:0] LINE1_BASE  = 7'h40;
	localparam logic [7:0] CMD_CLEAR   = 8'h01;

	// control characters
	localparam logic [7:0] CHAR_CR = 8'h0D;
	localparam logic [7:0] CHAR_LF = 8'h0A;
	localparam logic [7:0] CHAR_FF = 8'h0C;

	// action codes
	localparam logic ACT_CHAR = 1'b0;
	localparam logic ACT_MOVE = 1'b1;

	// register indexes
	localparam logic [1:0] REG_TOTAL_COLUMNS   = 2'd0;
	localparam logic [1:0] REG_ROWS_IN_USE     = 2'd1;
	localparam logic [1:0] REG_ROWS_CONFIGURED = 2'd2;

	localparam int PADDR_W = 4;

	typedef struct packed {
		logic [5:0] total_columns;
		logic [1:0] rows_in_use;
		logic [1:0] rows_configured;
	} cfg_t;

	typedef struct packed {
		logic       is_data;
		logic [7:0] bus_byte;
	} bus_wr_t;

	// one or two bus writes caused by an item
	typedef struct packed {
		logic    two;
		bus_wr_t w0;
		bus_wr_t w1;
	} plan_t;

endpackage

/* rtl/core/clwr_front.sv */
`timescale 1ns / 1ps

module clwr_front import clwr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       item_valid,
	output logic       item_stall,
	input  logic       action,
	input  logic [7:0] char_code,
	input  logic [5:0] target_column,
	input  logic [1:0] target_row,
	input  logic       q_full,
	output logic       push,
	output plan_t      plan
);

	logic [5:0] col_q, col_n;
	logic       line_q, line_n;
	logic [6:0] addr_q, addr_n;

	logic [5:0] eff, split;
	logic       move_ok;
	logic [5:0] pc_col;
	logic       pc_line, pc_line_o, pc_hit;
	logic [6:0] pc_addr;
	logic [6:0] next_col;
	logic       has_wr;
	logic       accept;
	bus_wr_t    cmd_wr, data_wr;

	assign item_stall = q_full;
	assign accept     = item_valid && !q_full;
	assign push       = accept && has_wr;

	always_comb begin
		eff   = (cfg.total_columns > 6'(MAX_COLUMNS)) ? 6'(MAX_COLUMNS) : cfg.total_columns;
		split = (cfg.rows_configured == 2'd2) ? (eff >> 1) : eff;

		move_ok = (target_column != 6'd0) && (target_column <= eff) &&
			(target_row != 2'd0) && (target_row <= cfg.rows_in_use) && (target_row != 2'd3);

		if (action == ACT_MOVE) begin
			pc_col  = 6'(target_column - 6'd1);
			pc_line = 1'(target_row - 2'd1);
		end else begin
			pc_col  = col_q;
			pc_line = line_q;
		end

		// set-address step at the split column or at column zero
		pc_hit    = 1'b0;
		pc_addr   = addr_q;
		pc_line_o = pc_line;
		if (pc_col == split) begin
			pc_hit = 1'b1;
			if (cfg.rows_in_use == 2'd1 && cfg.rows_configured == 2'd2)
				pc_addr = LINE1_BASE;
			if (cfg.rows_in_use == 2'd2) begin
				pc_line_o = ~pc_line;
				pc_addr   = pc_line_o ? (LINE1_BASE | {1'b0, pc_col}) : {1'b0, pc_col};
			end
		end else if (pc_col == 6'd0) begin
			pc_hit = 1'b1;
			if (cfg.rows_in_use == 2'd1 && cfg.rows_configured == 2'd2)
				pc_addr = 7'd0;
		end
		cmd_wr  = '{is_data: 1'b0, bus_byte: CMD_SETADDR | {1'b0, pc_addr}};
		data_wr = '{is_data: 1'b1, bus_byte: char_code};

		next_col = {1'b0, col_q} + 7'd1;

		col_n  = col_q;
		line_n = line_q;
		addr_n = addr_q;
		has_wr = 1'b0;
		plan   = '0;

		if (action == ACT_MOVE) begin
			if (move_ok) begin
				col_n   = pc_col;
				line_n  = pc_line_o;
				addr_n  = pc_addr;
				has_wr  = pc_hit;
				plan.w0 = cmd_wr;
			end
		end else begin
			unique case (char_code)
				CHAR_CR: begin
					has_wr  = 1'b1;
					plan.w0 = '{is_data: 1'b0, bus_byte: CMD_HOME};
					// wrap case on the second line
					if (col_q == eff && cfg.rows_configured == 2'd2 &&
						cfg.rows_in_use == 2'd2 && line_q) begin
						line_n   = 1'b0;
						plan.two = 1'b1;
						plan.w1  = '{is_data: 1'b0, bus_byte: CMD_SETADDR};
					end
					col_n = 6'd0;
				end
				CHAR_LF: begin
					col_n = 6'd0;
					if (cfg.rows_in_use == 2'd2)
						line_n = 1'b1;
					has_wr  = 1'b1;
					plan.w0 = '{is_data: 1'b0,
						bus_byte: CMD_SETADDR | ((line_n) ? {1'b0, LINE1_BASE} : 8'h00)};
				end
				CHAR_FF: begin
					col_n   = 6'd0;
					line_n  = 1'b0;
					has_wr  = 1'b1;
					plan.w0 = '{is_data: 1'b0, bus_byte: CMD_CLEAR};
				end
				default: begin
					has_wr  = 1'b1;
					line_n  = pc_line_o;
					addr_n  = pc_addr;
					if (pc_hit) begin
						plan.two = 1'b1;
						plan.w0  = cmd_wr;
						plan.w1  = data_wr;
					end else begin
						plan.w0 = data_wr;
					end
					col_n = (next_col >= {1'b0, eff}) ? 6'd0 : next_col[5:0];
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			line_q <= 1'b0;
			addr_q <= '0;
		end else if (accept) begin
			col_q  <= col_n;
			line_q <= line_n;
			addr_q <= addr_n;
		end
	end

endmodule

/* rtl/core/clwr_queue.sv */
`timescale 1ns / 1ps

module clwr_queue import clwr_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  plan_t push_data,
	input  logic  pop,
	output plan_t head,
	output logic  head_valid,
	output logic  full
);

	plan_t      mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;

	assign head       = mem_q[rd_ptr_q];
	assign head_valid = (count_q != 2'd0);
	assign full       = (count_q == 2'd2);

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop)
				count_q <= count_q + 2'd1;
			else if (pop && !push)
				count_q <= count_q - 2'd1;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("queue count out of range");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != 2'd0)
		else $error("pop from empty queue");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q != 2'd2))
		else $error("push into full queue");

endmodule

/* rtl/core/clwr_back.sv */
`timescale 1ns / 1ps

module clwr_back import clwr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  plan_t      head,
	input  logic       head_valid,
	output logic       pop,
	output logic       wr_valid,
	input  logic       wr_stall,
	output logic       is_data,
	output logic [7:0] bus_byte,
	output logic       last
);

	logic    wr_valid_q;
	bus_wr_t wr_q;
	logic    last_q;
	logic    half_q;
	logic    load;
	logic    load_last;

	assign load      = head_valid && (!wr_valid_q || !wr_stall);
	assign load_last = half_q || !head.two;
	assign pop       = load && load_last;

	assign wr_valid = wr_valid_q;
	assign is_data  = wr_q.is_data;
	assign bus_byte = wr_q.bus_byte;
	assign last     = last_q;

	always_ff @(posedge clk) begin
		if (load) begin
			wr_q   <= half_q ? head.w1 : head.w0;
			last_q <= load_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_valid_q <= 1'b0;
			half_q     <= 1'b0;
		end else begin
			if (load)
				wr_valid_q <= 1'b1;
			else if (!wr_stall)
				wr_valid_q <= 1'b0;
			if (load)
				half_q <= !load_last;
		end
	end

	// second write of an entry follows straight after the first
	a_second_follows: assert property (@(posedge clk) disable iff (!arst_n)
		wr_valid_q && !wr_stall && !last_q |=> wr_valid_q)
		else $error("second write of an item missing");

	a_half_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		half_q |-> head_valid)
		else $error("half-emitted entry lost from queue");

endmodule

/* rtl/core/char_lcd_cursor_writer.sv */
`timescale 1ns / 1ps
// an accepted item is written into the queue, then loaded into the output register
// items that cause one write are taken one a cycle while the output is not stalled;
// the single output register sends one bus write per cycle while wr_stall is low
// a two-entry queue between decode and output lets the input run ahead of a stalled output
// reset clears cursor column, line, ddram address, queue and output valid;
// registers return to 16 columns, one row in use, two-line controller setup

module char_lcd_cursor_writer import clwr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic               action,
	input  logic [7:0]         char_code,
	input  logic [5:0]         target_column,
	input  logic [1:0]         target_row,
	output logic               wr_valid,
	input  logic               wr_stall,
	output logic               is_data,
	output logic [7:0]         bus_byte,
	output logic               last
);

	cfg_t       cfg_q;
	logic       q_full, push, pop, head_valid;
	plan_t      plan, head;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.total_columns   <= 6'd16;
			cfg_q.rows_in_use     <= 2'd1;
			cfg_q.rows_configured <= 2'd2;
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_idx)
				REG_TOTAL_COLUMNS:   cfg_q.total_columns   <= pwdata[5:0];
				REG_ROWS_IN_USE:     cfg_q.rows_in_use     <= pwdata[1:0];
				REG_ROWS_CONFIGURED: cfg_q.rows_configured <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_TOTAL_COLUMNS:   prdata = {26'd0, cfg_q.total_columns};
			REG_ROWS_IN_USE:     prdata = {30'd0, cfg_q.rows_in_use};
			REG_ROWS_CONFIGURED: prdata = {30'd0, cfg_q.rows_configured};
			default:             prdata = '0;
		endcase
	end

	clwr_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.item_valid    (item_valid),
		.item_stall    (item_stall),
		.action        (action),
		.char_code     (char_code),
		.target_column (target_column),
		.target_row    (target_row),
		.q_full        (q_full),
		.push          (push),
		.plan          (plan)
	);

	clwr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (plan),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid),
		.full       (q_full)
	);

	clwr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.wr_valid   (wr_valid),
		.wr_stall   (wr_stall),
		.is_data    (is_data),
		.bus_byte   (bus_byte),
		.last       (last)
	);

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
	import clwr_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int ITEMS_PER_PH = 100;
	localparam int PHASES       = 12;
	localparam int DRAIN_CYCLES = 6;

	typedef struct packed {
		logic       is_data;
		logic [7:0] bus_byte;
		logic       last;
	} lcd_write_t;

	// cursor tracking and the bus writes still owed by the block
	class lcd_scoreboard;
		logic [5:0] columns_reg;
		logic [1:0] rows_used;
		logic [1:0] rows_cfg;
		logic [5:0] column;
		logic       line;
		logic [6:0] ddram;
		lcd_write_t writes_due[$];
		bus_wr_t    step_writes[$];
		int         errors;

		function new();
			columns_reg = 6'd16;
			rows_used   = 2'd1;
			rows_cfg    = 2'd2;
			column      = '0;
			line        = 1'b0;
			ddram       = '0;
			errors      = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [5:0] value);
			case (idx)
			REG_TOTAL_COLUMNS:   columns_reg = value;
			REG_ROWS_IN_USE:     rows_used = value[1:0];
			REG_ROWS_CONFIGURED: rows_cfg = value[1:0];
			default: ;
			endcase
		endfunction

		function int eff_columns();
			return (columns_reg > MAX_COLUMNS) ? MAX_COLUMNS : int'(columns_reg);
		endfunction

		function int pending();
			return writes_due.size();
		endfunction

		function void add_write(logic d, logic [7:0] b);
			bus_wr_t w;
			w.is_data  = d;
			w.bus_byte = b;
			step_writes.push_back(w);
		endfunction

		// set-address step at column 0 or at the split column
		function void place_cursor();
			int split;
			split = (rows_cfg == 2'd2) ? eff_columns() / 2 : eff_columns();
			if (column == split) begin
				if (rows_used == 2'd1 && rows_cfg == 2'd2)
					ddram = LINE1_BASE;
				if (rows_used == 2'd2) begin
					line  = ~line;
					ddram = line ? ({1'b0, column} | LINE1_BASE) : {1'b0, column};
				end
				add_write(1'b0, CMD_SETADDR | {1'b0, ddram});
			end else if (column == 6'd0) begin
				if (rows_used == 2'd1 && rows_cfg == 2'd2)
					ddram = '0;
				add_write(1'b0, CMD_SETADDR | {1'b0, ddram});
			end
		endfunction

		function void note_item(logic act, logic [7:0] ch, logic [5:0] tcol, logic [1:0] trow);
			int         nxt;
			lcd_write_t e;
			step_writes.delete();
			if (act == ACT_MOVE) begin
				// out-of-range moves are dropped without any change
				if (tcol >= 6'd1 && tcol <= eff_columns() && trow >= 2'd1 &&
				    trow <= rows_used && trow <= 2'd2) begin
					column = tcol - 6'd1;
					line   = ~trow[0];
					place_cursor();
				end
			end else if (ch == CHAR_CR) begin
				add_write(1'b0, CMD_HOME);
				if (column == eff_columns() && rows_cfg == 2'd2 && rows_used == 2'd2 && line) begin
					line = 1'b0;
					add_write(1'b0, CMD_SETADDR);
				end
				column = '0;
			end else if (ch == CHAR_LF) begin
				column = '0;
				if (rows_used == 2'd2)
					line = 1'b1;
				add_write(1'b0, CMD_SETADDR | (line ? {1'b0, LINE1_BASE} : 8'h00));
			end else if (ch == CHAR_FF) begin
				column = '0;
				line   = 1'b0;
				add_write(1'b0, CMD_CLEAR);
			end else begin
				place_cursor();
				add_write(1'b1, ch);
				nxt    = column + 1;
				column = (nxt >= eff_columns()) ? 6'd0 : nxt[5:0];
			end
			foreach (step_writes[i]) begin
				e.is_data  = step_writes[i].is_data;
				e.bus_byte = step_writes[i].bus_byte;
				e.last     = (i == step_writes.size() - 1);
				writes_due.push_back(e);
			end
		endfunction

		task report_mismatch(string msg);
			$display("mismatch: %s", msg);
			errors++;
		endtask

		task check_result(logic d, logic [7:0] b, logic l);
			lcd_write_t e;
			if (writes_due.size() == 0) begin
				report_mismatch($sformatf("write data=%0b byte=%02h with nothing due", d, b));
				return;
			end
			e = writes_due.pop_front();
			if (d !== e.is_data)
				report_mismatch($sformatf("is_data %0b, expected %0b", d, e.is_data));
			if (b !== e.bus_byte)
				report_mismatch($sformatf("bus_byte %02h, expected %02h", b, e.bus_byte));
			if (l !== e.last)
				report_mismatch($sformatf("last %0b, expected %0b", l, e.last));
		endtask
	endclass

	logic               clk = 1'b0;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;
	logic               item_valid;
	logic               item_stall;
	logic               action;
	logic [7:0]         char_code;
	logic [5:0]         target_column;
	logic [1:0]         target_row;
	logic               wr_valid;
	logic               wr_stall;
	logic               is_data;
	logic [7:0]         bus_byte;
	logic               last;

	lcd_scoreboard sb;
	int send_idle_pct;
	int recv_stall_pct;
	int cycle_count = 0;

	// per-phase settings, -1 picks a random legal value
	int phase_columns[PHASES] = '{16, 2, 40, 2, 63, 7, 0, 1, 40, 3, -1, 16};
	int phase_rows[PHASES]    = '{1, 1, 2, 2, 2, 1, 3, 0, 1, 2, -1, 2};
	int phase_rcfg[PHASES]    = '{2, 1, 2, 2, 1, 2, 3, 0, 2, 2, -1, 1};

	char_lcd_cursor_writer dut (.*);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// bus write side: take a write when not stalled, then pick the next stall
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && wr_valid && !wr_stall)
				sb.check_result(is_data, bus_byte, last);
			wr_stall <= ($urandom_range(0, 99) < recv_stall_pct);
		end
	end

	task send_item(logic act, logic [7:0] ch, logic [5:0] tcol, logic [1:0] trow);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid    <= 1'b1;
		action        <= act;
		char_code     <= ch;
		target_column <= tcol;
		target_row    <= trow;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		sb.note_item(act, ch, tcol, trow);
	endtask

	// drain all owed writes, then give a move with no write time to finish
	task settle();
		item_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// write a register, then read it back
	task program_register(logic [1:0] idx, int value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		sb.set_reg(idx, value[5:0]);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== value)
			sb.report_mismatch($sformatf("register %0d reads %0h, expected %0h", idx, prdata, value));
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task program_all(int cols, int rows, int rcfg);
		program_register(REG_TOTAL_COLUMNS, cols);
		program_register(REG_ROWS_IN_USE, rows);
		program_register(REG_ROWS_CONFIGURED, rcfg);
	endtask

	// mostly character items so the cursor walks across splits and wraps
	task random_item();
		int         pick;
		int         eff;
		int         rmax;
		logic       act;
		logic [7:0] ch;
		logic [5:0] tcol;
		logic [1:0] trow;
		pick = $urandom_range(0, 99);
		eff  = sb.eff_columns();
		rmax = (sb.rows_used == 2'd2) ? 2 : 1;
		act  = ACT_CHAR;
		ch   = $urandom_range(0, 255);
		tcol = $urandom_range(0, 63);
		trow = $urandom_range(0, 3);
		if (pick < 10) begin
			ch = CHAR_CR;
		end else if (pick < 18) begin
			ch = CHAR_LF;
		end else if (pick < 23) begin
			ch = CHAR_FF;
		end else if (pick >= 80) begin
			act = ACT_MOVE;
			if (pick < 95 && eff > 0) begin
				tcol = $urandom_range(1, eff);
				trow = $urandom_range(1, rmax);
			end
		end
		send_item(act, ch, tcol, trow);
	endtask

	initial begin
		sb = new();
		arst_n        <= 1'b0;
		psel          <= 1'b0;
		penable       <= 1'b0;
		pwrite        <= 1'b0;
		paddr         <= '0;
		pwdata        <= '0;
		item_valid    <= 1'b0;
		action        <= ACT_CHAR;
		char_code     <= '0;
		target_column <= '0;
		target_row    <= '0;
		wr_stall      <= 1'b0;
		send_idle_pct  = 14;
		recv_stall_pct = 50;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: 16 columns, one row split at half width
		send_item(ACT_CHAR, 8'h00, 6'd63, 2'd3);
		send_item(ACT_CHAR, 8'hFF, 6'd0, 2'd0);
		send_item(ACT_MOVE, 8'h00, 6'd9, 2'd1);
		send_item(ACT_CHAR, 8'h41, 6'd0, 2'd0);
		send_item(ACT_MOVE, 8'hFF, 6'd16, 2'd1);
		send_item(ACT_CHAR, 8'h5A, 6'd0, 2'd0);
		send_item(ACT_MOVE, 8'hFF, 6'd0, 2'd1);
		send_item(ACT_MOVE, 8'hFF, 6'd63, 2'd3);
		send_item(ACT_MOVE, 8'h00, 6'd1, 2'd2);
		send_item(ACT_MOVE, 8'h00, 6'd1, 2'd0);
		send_item(ACT_CHAR, CHAR_CR, 6'd0, 2'd0);
		send_item(ACT_CHAR, CHAR_LF, 6'd0, 2'd0);
		send_item(ACT_CHAR, CHAR_FF, 6'd0, 2'd0);

		// carriage return with the cursor at a shrunk column count on line two
		settle();
		program_all(40, 2, 2);
		send_item(ACT_MOVE, 8'h00, 6'd11, 2'd2);
		settle();
		program_register(REG_TOTAL_COLUMNS, 10);
		send_item(ACT_CHAR, CHAR_CR, 6'd0, 2'd0);
		send_item(ACT_CHAR, CHAR_LF, 6'd0, 2'd0);
		send_item(ACT_MOVE, 8'h00, 6'd6, 2'd2);

		// zero and one column, odd row settings
		settle();
		program_all(0, 3, 0);
		send_item(ACT_CHAR, 8'h78, 6'd0, 2'd0);
		send_item(ACT_MOVE, 8'h00, 6'd1, 2'd1);
		settle();
		program_all(1, 0, 3);
		send_item(ACT_CHAR, 8'h80, 6'd0, 2'd0);
		send_item(ACT_MOVE, 8'h00, 6'd1, 2'd1);

		// column count above the limit
		settle();
		program_all(63, 2, 2);
		send_item(ACT_MOVE, 8'h00, 6'd40, 2'd2);
		send_item(ACT_CHAR, 8'h7F, 6'd0, 2'd0);
		send_item(ACT_MOVE, 8'h00, 6'd41, 2'd1);

		for (int ph = 0; ph < PHASES; ph++) begin
			send_idle_pct  = (ph < 4) ? 14 : (ph < 8) ? 50 : 0;
			recv_stall_pct = (ph < 4) ? 50 : (ph < 8) ? 14 : 0;
			settle();
			program_all((phase_columns[ph] < 0) ? $urandom_range(2, 40) : phase_columns[ph],
			            (phase_rows[ph] < 0) ? $urandom_range(1, 2) : phase_rows[ph],
			            (phase_rcfg[ph] < 0) ? $urandom_range(1, 2) : phase_rcfg[ph]);
			repeat (ITEMS_PER_PH) random_item();
		end

		settle();
		repeat (20) @(posedge clk);
		if (sb.errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

/* sim.f */
rtl/core/clwr_pkg.sv
rtl/core/clwr_front.sv
rtl/core/clwr_queue.sv
rtl/core/clwr_back.sv
rtl/core/char_lcd_cursor_writer.sv
tb/testbench.sv
